[design/tpic_pkg.sv]
// ----------------------------------------------------------------------------
// tpic_pkg
// Shared types and constants of the timer pair with interrupt controller.
// ----------------------------------------------------------------------------
package tpic_pkg;

   localparam int MODE_BIT_DEFAULT   = 6;
   localparam int NUM_TIMERS_DEFAULT = 2;
   // timers that own a register window (0-3 and 4-7)
   localparam int NUM_REG_TIMERS     = 2;
   localparam int TIMER_IRQ_BASE     = 4;

   localparam logic [15:0] PRESCALE_RESET = 16'd50;
   localparam logic [31:0] FREE_RELOAD    = 32'h0000_ffff;
   localparam logic [15:0] FIQ_MASK       = 16'h0001;
   localparam logic [15:0] IRQ_MASK       = 16'hfffe;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_READ  = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_NONE  = 2'd3
   } tpic_action_type;

   typedef enum logic [1:0] {
      SUB_LOAD  = 2'd0,
      SUB_COUNT = 2'd1,
      SUB_CTRL  = 2'd2,
      SUB_CLEAR = 2'd3
   } tpic_tsub_type;

   localparam logic [4:0] REG_DEBUG    = 5'd8;
   localparam logic [4:0] REG_DEBUG_HI = 5'd9;
   localparam logic [4:0] REG_STAT0    = 5'd10;
   localparam logic [4:0] REG_STAT1    = 5'd11;
   localparam logic [4:0] REG_MASK0    = 5'd12;
   localparam logic [4:0] REG_MASK1    = 5'd13;
   localparam logic [4:0] REG_MCLR0    = 5'd14;
   localparam logic [4:0] REG_MCLR1    = 5'd15;
   localparam logic [4:0] REG_DEVCFG   = 5'd16;

   typedef struct packed {
      logic          tick;
      logic          wr_load;
      logic          wr_ctrl;
      logic          idx;
      tpic_tsub_type sub;
      logic [31:0]   data;
   } tpic_tmr_ctl_type;

   typedef struct packed {
      logic                      rd_stat0;
      logic                      rd_stat1;
      logic                      wr_mask0;
      logic                      wr_mask1;
      logic                      clr_mask0;
      logic                      clr_mask1;
      logic [NUM_REG_TIMERS-1:0] clr_timer;
      logic [31:0]               data;
   } tpic_int_ctl_type;

endpackage

[design/tpic_if.sv]
// ----------------------------------------------------------------------------
// tpic_if
// Request and response channels of the timer pair with interrupt controller.
// ----------------------------------------------------------------------------
interface tpic_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [4:0]  reg_index;
   logic [31:0] write_data;

   modport source (output valid, output action, output reg_index, output write_data,
                   input ready);
   modport sink   (input valid, input action, input reg_index, input write_data,
                   output ready);
endinterface

interface tpic_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        irq_active;
   logic        fiq_active;

   modport source (output valid, output read_data, output irq_active, output fiq_active,
                   input ready);
   modport sink   (input valid, input read_data, input irq_active, input fiq_active,
                   output ready);
endinterface

[design/tpic_timers.sv]
// ----------------------------------------------------------------------------
// tpic_timers
// Prescaler, down-counting timers and the debug underflow counter.
// ----------------------------------------------------------------------------
module tpic_timers #(
   parameter int MODE_BIT   = tpic_pkg::MODE_BIT_DEFAULT,
   parameter int NUM_TIMERS = tpic_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [15:0]                prescale_reload,
   input  tpic_pkg::tpic_tmr_ctl_type ctl,
   output logic [31:0]                rdata,
   output logic [31:0]                debug_count,
   output logic [NUM_TIMERS-1:0]      expire
);
   import tpic_pkg::*;

   logic [15:0] pre_count_ff, pre_count_in;
   logic [31:0] count_ff [NUM_TIMERS];
   logic [31:0] count_in [NUM_TIMERS];
   logic [31:0] load_ff  [NUM_TIMERS];
   logic [31:0] load_in  [NUM_TIMERS];
   logic [31:0] ctrl_ff  [NUM_TIMERS];
   logic [31:0] ctrl_in  [NUM_TIMERS];
   logic [31:0] debug_ff, debug_in;
   logic        step;

   always_comb begin
      step         = ctl.tick && (pre_count_ff == 16'd0);
      pre_count_in = pre_count_ff;
      if (ctl.tick) begin
         pre_count_in = step ? prescale_reload : pre_count_ff - 16'd1;
      end
      debug_in = step ? debug_ff + 32'd1 : debug_ff;
      rdata    = '0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
         count_in[t] = count_ff[t];
         load_in[t]  = load_ff[t];
         ctrl_in[t]  = ctrl_ff[t];
         expire[t]   = step && (count_ff[t] == 32'd0);
         if (step) begin
            if (count_ff[t] == 32'd0) begin
               count_in[t] = ctrl_ff[t][MODE_BIT] ? load_ff[t] : FREE_RELOAD;
            end else begin
               count_in[t] = count_ff[t] - 32'd1;
            end
         end
         // only the first two timers have a register window
         if (t < NUM_REG_TIMERS && ctl.idx == 1'(t)) begin
            if (ctl.wr_load) begin
               load_in[t] = ctl.data;
            end
            if (ctl.wr_ctrl) begin
               ctrl_in[t] = ctl.data;
            end
            unique case (ctl.sub)
               SUB_LOAD:  rdata = load_ff[t];
               SUB_COUNT: rdata = count_ff[t];
               SUB_CTRL:  rdata = ctrl_ff[t];
               SUB_CLEAR: rdata = '0;
               default:   rdata = '0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_count_ff <= PRESCALE_RESET;
         debug_ff     <= '0;
         for (int t = 0; t < NUM_TIMERS; t++) begin
            count_ff[t] <= '0;
            load_ff[t]  <= '0;
            ctrl_ff[t]  <= '0;
         end
      end else begin
         pre_count_ff <= pre_count_in;
         debug_ff     <= debug_in;
         for (int t = 0; t < NUM_TIMERS; t++) begin
            count_ff[t] <= count_in[t];
            load_ff[t]  <= load_in[t];
            ctrl_ff[t]  <= ctrl_in[t];
         end
      end
   end

   assign debug_count = debug_ff;

endmodule

[design/tpic_intc.sv]
// ----------------------------------------------------------------------------
// tpic_intc
// Interrupt status and mask words, with the masked fiq and irq requests.
// ----------------------------------------------------------------------------
module tpic_intc #(
   parameter int NUM_TIMERS = tpic_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tpic_pkg::tpic_int_ctl_type ctl,
   input  logic [NUM_TIMERS-1:0]      expire,
   output logic [31:0]                stat0,
   output logic [31:0]                stat1,
   output logic [31:0]                mask0,
   output logic [31:0]                mask1,
   output logic                       irq_next,
   output logic                       fiq_next
);
   import tpic_pkg::*;

   logic [31:0] stat0_ff, stat0_in;
   logic [31:0] stat1_ff, stat1_in;
   logic [31:0] mask0_ff, mask0_in;
   logic [31:0] mask1_ff, mask1_in;
   logic [31:0] req;

   always_comb begin
      stat0_in = ctl.rd_stat0 ? '0 : stat0_ff;
      for (int t = 0; t < NUM_TIMERS; t++) begin
         if (expire[t]) begin
            stat0_in[TIMER_IRQ_BASE + t] = 1'b1;
         end
      end
      for (int t = 0; t < NUM_REG_TIMERS; t++) begin
         if (ctl.clr_timer[t]) begin
            stat0_in[TIMER_IRQ_BASE + t] = 1'b0;
         end
      end
      stat1_in = ctl.rd_stat1 ? '0 : stat1_ff;

      priority if (ctl.wr_mask0) begin
         mask0_in = ctl.data;
      end else if (ctl.clr_mask0) begin
         mask0_in = mask0_ff & ~ctl.data;
      end else begin
         mask0_in = mask0_ff;
      end
      priority if (ctl.wr_mask1) begin
         mask1_in = ctl.data;
      end else if (ctl.clr_mask1) begin
         mask1_in = mask1_ff & ~ctl.data;
      end else begin
         mask1_in = mask1_ff;
      end

      // requests as they stand after this item
      req      = (stat0_in & mask0_in) | (stat1_in & mask1_in);
      irq_next = |(req[15:0] & IRQ_MASK);
      fiq_next = |(req[15:0] & FIQ_MASK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat0_ff <= '0;
         stat1_ff <= '0;
         mask0_ff <= '0;
         mask1_ff <= '0;
      end else begin
         stat0_ff <= stat0_in;
         stat1_ff <= stat1_in;
         mask0_ff <= mask0_in;
         mask1_ff <= mask1_in;
      end
   end

   assign stat0 = stat0_ff;
   assign stat1 = stat1_ff;
   assign mask0 = mask0_ff;
   assign mask1 = mask1_ff;

endmodule

[design/timer_pair_with_interrupt_controller.sv]
// ----------------------------------------------------------------------------
// timer_pair_with_interrupt_controller
// Prescaled reload timers with a two-word masked interrupt controller.
// ----------------------------------------------------------------------------
// Each item on the request channel is a tick, a register read or a register
// write, and gives exactly one response item with the read value and the fiq
// and irq lines as they stand after that item. Unless stalled, one item is
// taken every clock; each is held in the input register, worked in a single
// pass of logic as it moves to the response register and offered from there.
// Back-pressure stalls the input register only once the response register is
// full. The user must write the prescaler restart value through the csr port
// while idle; the block does not enforce it. No clearing pass after reset.
module timer_pair_with_interrupt_controller #(
   parameter int MODE_BIT   = tpic_pkg::MODE_BIT_DEFAULT,
   parameter int NUM_TIMERS = tpic_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   tpic_req_if.sink    req_chan,
   tpic_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import tpic_pkg::*;

   logic [15:0]      reload_ff;
   logic             s1_valid_ff, s1_valid_in;
   tpic_action_type  s1_action_ff;
   logic [4:0]       s1_reg_index_ff;
   logic [31:0]      s1_write_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      read_data_ff, read_data_in;
   logic             irq_ff, fiq_ff;
   logic [31:0]      devcfg_ff, devcfg_in;
   logic             accept, advance, rsp_load;
   logic             timer_ok, is_timer_reg;
   tpic_tmr_ctl_type tctl;
   tpic_int_ctl_type ictl;
   logic [31:0]      tmr_rdata, debug_count;
   logic [31:0]      stat0, stat1, mask0, mask1;
   logic             irq_next, fiq_next;
   logic [NUM_TIMERS-1:0] expire;
   logic [31:0]      rd_value;

   assign rsp_load       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && rsp_load;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in   = rsp_load ? s1_valid_ff : rsp_valid_ff;

   assign is_timer_reg = s1_reg_index_ff < REG_DEBUG;
   assign timer_ok     = (NUM_TIMERS > 1) || !s1_reg_index_ff[2];

   // decode of the item in the input register
   always_comb begin
      tctl      = '0;
      ictl      = '0;
      tctl.idx  = s1_reg_index_ff[2];
      tctl.sub  = tpic_tsub_type'(s1_reg_index_ff[1:0]);
      tctl.data = s1_write_data_ff;
      ictl.data = s1_write_data_ff;
      devcfg_in = devcfg_ff;
      if (advance) begin
         unique case (s1_action_ff)
            ACT_TICK: begin
               tctl.tick = 1'b1;
            end
            ACT_READ: begin
               ictl.rd_stat0 = (s1_reg_index_ff == REG_STAT0);
               ictl.rd_stat1 = (s1_reg_index_ff == REG_STAT1);
            end
            ACT_WRITE: begin
               if (is_timer_reg) begin
                  tctl.wr_load = (tctl.sub == SUB_LOAD);
                  tctl.wr_ctrl = (tctl.sub == SUB_CTRL);
                  if (tctl.sub == SUB_CLEAR && timer_ok) begin
                     ictl.clr_timer[s1_reg_index_ff[2]] = 1'b1;
                  end
               end else begin
                  ictl.wr_mask0  = (s1_reg_index_ff == REG_MASK0);
                  ictl.wr_mask1  = (s1_reg_index_ff == REG_MASK1);
                  ictl.clr_mask0 = (s1_reg_index_ff == REG_MCLR0);
                  ictl.clr_mask1 = (s1_reg_index_ff == REG_MCLR1);
                  if (s1_reg_index_ff == REG_DEVCFG) begin
                     devcfg_in = s1_write_data_ff;
                  end
               end
            end
            ACT_NONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (is_timer_reg) begin
         rd_value = tmr_rdata;
      end else begin
         unique case (s1_reg_index_ff)
            REG_DEBUG:    rd_value = debug_count;
            REG_DEBUG_HI: rd_value = '0;
            REG_STAT0:    rd_value = stat0;
            REG_STAT1:    rd_value = stat1;
            REG_MASK0:    rd_value = mask0;
            REG_MASK1:    rd_value = mask1;
            REG_DEVCFG:   rd_value = devcfg_ff;
            default:      rd_value = '0;
         endcase
      end
      read_data_in = (s1_action_ff == ACT_READ) ? rd_value : '0;
   end

   tpic_timers #(
      .MODE_BIT   (MODE_BIT),
      .NUM_TIMERS (NUM_TIMERS)
   ) u_timers (
      .clock           (clock),
      .reset           (reset),
      .prescale_reload (reload_ff),
      .ctl             (tctl),
      .rdata           (tmr_rdata),
      .debug_count     (debug_count),
      .expire          (expire)
   );

   tpic_intc #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_intc (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ictl),
      .expire   (expire),
      .stat0    (stat0),
      .stat1    (stat1),
      .mask0    (mask0),
      .mask1    (mask1),
      .irq_next (irq_next),
      .fiq_next (fiq_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff    <= PRESCALE_RESET;
         devcfg_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            reload_ff <= csr_wr_data;
         end
         devcfg_ff    <= devcfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff     <= tpic_action_type'(req_chan.action);
         s1_reg_index_ff  <= req_chan.reg_index;
         s1_write_data_ff <= req_chan.write_data;
      end
      if (advance) begin
         read_data_ff <= read_data_in;
         irq_ff       <= irq_next;
         fiq_ff       <= fiq_next;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_data  = read_data_ff;
   assign rsp_chan.irq_active = irq_ff;
   assign rsp_chan.fiq_active = fiq_ff;

   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      advance && s1_action_ff != ACT_READ |=> rsp_chan.read_data == '0)
      else $error("non-read item gave nonzero read data");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_chan.ready)
      else $error("input stalled while response register empty");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_reg_index_ff)
                                  && $stable(s1_write_data_ff))
      else $error("stalled item in input register lost or changed");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("item left input register without a response");

endmodule
